FILE: hdl/edp_pkg.sv
// Shared types, constants and helpers for the edit distance engine.
`timescale 1ns / 1ps

package edp_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int CHAR_W      = 16;
  localparam int COST_W      = 16;
  localparam int OP_W        = 2;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
  } item_t;

  function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
    return (v == COST_MAX) ? COST_MAX : v + COST_W'(1);
  endfunction

  function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                            input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: hdl/edp_if.sv
// Valid/ready channel interfaces for the input items and the results.
`timescale 1ns / 1ps

interface edp_in_if
  import edp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output operation, output char_code, input ready);
  modport sink   (input valid, input operation, input char_code, output ready);
endinterface

interface edp_out_if
  import edp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] distance;
  logic              pattern_overflow;

  modport source (output valid, output distance, output pattern_overflow, input ready);
  modport sink   (input valid, input distance, input pattern_overflow, output ready);
endinterface

FILE: hdl/edp_front.sv
// Front end: accepts input transfers, decodes the operation, buffers in a short queue.
`timescale 1ns / 1ps

module edp_front
  import edp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  edp_in_if.sink in_i,
  output logic   item_valid_o,
  output item_t  item_o,
  input  logic   item_ready_i
);

  item_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  item_t             in_item;

  assign in_item.op        = op_e'(in_i.operation);
  assign in_item.char_code = in_i.char_code;

  assign in_i.ready   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

FILE: hdl/edp_back.sv
// Back end: pattern store, row walk of the cost table and the result register.
`timescale 1ns / 1ps

module edp_back
  import edp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mode_i,
  input  logic      item_valid_i,
  input  item_t     item_i,
  output logic      item_ready_o,
  edp_out_if.source out_o
);

  back_state_e state_q, state_d;

  // pattern chars and row costs 1..MAX_PATTERN live in memories
  logic [CHAR_W-1:0] pat_mem [MAX_PATTERN];
  logic [COST_W-1:0] row_mem [MAX_PATTERN];
  logic [CHAR_W-1:0] pat_rd_q;
  logic [COST_W-1:0] row_rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              pat_we, row_we;
  logic [IDX_W-1:0]  pat_wa, row_wa;
  logic [COST_W-1:0] row_wd;

  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              fresh_q, fresh_d;    // row still reads as 0..len
  logic [COST_W-1:0] row0_q, row0_d;
  logic [COST_W-1:0] left_q, left_d;
  logic [COST_W-1:0] diag_q, diag_d;
  logic [COST_W-1:0] best_q, best_d;
  logic [COST_W-1:0] last_q, last_d;      // row cost at the pattern length
  logic [CHAR_W-1:0] char_q, char_d;
  logic [IDX_W-1:0]  j_q, j_d;

  logic              out_valid_q, out_valid_d;
  logic [COST_W-1:0] dist_q, dist_d;
  logic              out_ovf_q, out_ovf_d;

  logic              out_free, take, cell_last;
  logic [COST_W-1:0] up, del_c, ins_c, sub_c, cell_v, left0;
  logic [LEN_W-1:0]  restart_len;
  logic              restart;

  assign out_free     = !out_valid_q || out_o.ready;
  assign item_ready_o = (state_q == ST_IDLE) && ((item_i.op != OP_END) || out_free);
  assign take         = item_valid_i && item_ready_o;
  assign cell_last    = ((LEN_W'(j_q) + LEN_W'(1)) == len_q);

  assign out_o.valid            = out_valid_q;
  assign out_o.distance         = dist_q;
  assign out_o.pattern_overflow = out_ovf_q;

  // one cell of the recurrence
  assign up     = fresh_q ? (COST_W'(j_q) + COST_W'(1)) : row_rd_q;
  assign del_c  = sat_inc(up);
  assign ins_c  = sat_inc(left_q);
  assign sub_c  = (pat_rd_q != char_q) ? sat_inc(diag_q) : diag_q;
  assign cell_v = min2(del_c, min2(ins_c, sub_c));
  assign left0  = mode_i ? '0 : sat_inc(row0_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (item_i.op == OP_TEXT) && (len_q != '0)) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (cell_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    fresh_d     = fresh_q;
    row0_d      = row0_q;
    left_d      = left_q;
    diag_d      = diag_q;
    best_d      = best_q;
    last_d      = last_q;
    char_d      = char_q;
    j_d         = j_q;
    out_valid_d = out_valid_q;
    dist_d      = dist_q;
    out_ovf_d   = out_ovf_q;
    pat_we      = 1'b0;
    pat_wa      = len_q[IDX_W-1:0];
    row_we      = 1'b0;
    row_wa      = j_q;
    row_wd      = cell_v;
    rd_addr     = '0;
    restart     = 1'b0;
    restart_len = len_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (item_i.op)
            OP_CLEAR: begin
              len_d       = '0;
              ovf_d       = 1'b0;
              restart     = 1'b1;
              restart_len = '0;
            end
            OP_APPEND: begin
              restart = 1'b1;
              if (len_q < LEN_W'(MAX_PATTERN)) begin
                pat_we      = 1'b1;
                len_d       = len_q + LEN_W'(1);
                restart_len = len_q + LEN_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_TEXT: begin
              row0_d = left0;
              left_d = left0;
              diag_d = row0_q;
              char_d = item_i.char_code;
              j_d    = '0;
              if (len_q == '0) begin
                best_d = min2(best_q, left0);
                last_d = left0;
              end
            end
            OP_END: begin
              out_valid_d = 1'b1;
              dist_d      = mode_i ? best_q : last_q;
              out_ovf_d   = ovf_q;
              restart     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROW: begin
        row_we  = 1'b1;
        diag_d  = up;
        left_d  = cell_v;
        j_d     = j_q + IDX_W'(1);
        rd_addr = j_q + IDX_W'(1);
        if (cell_last) begin
          best_d  = min2(best_q, cell_v);
          last_d  = cell_v;
          fresh_d = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (restart) begin
      row0_d  = '0;
      fresh_d = 1'b1;
      best_d  = COST_W'(restart_len);
      last_d  = COST_W'(restart_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      fresh_q     <= 1'b1;
      row0_q      <= '0;
      best_q      <= '0;
      last_q      <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      fresh_q     <= fresh_d;
      row0_q      <= row0_d;
      best_q      <= best_d;
      last_q      <= last_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q    <= left_d;
    diag_q    <= diag_d;
    char_q    <= char_d;
    dist_q    <= dist_d;
    out_ovf_q <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= item_i.char_code;
    end
    pat_rd_q <= pat_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_rd_q <= row_mem[rd_addr];
  end

endmodule

FILE: hdl/edit_distance_engine_top.sv
// Top level of the edit distance engine: config register, front queue and back end.
`timescale 1ns / 1ps
// Throughput: a text char is handled by the single cell-update unit, which walks the
//   row-cost memory one entry per cycle up to L, the current pattern length; no new item
//   is taken until the row is done, and an end-of-text waits while the output register is full.
// Timing: an input transfer reaches the back end through the registered 2-entry queue;
//   the result of an end-of-text sits in the output register the cycle after it is taken.
// Reset: rst_ni (async, active low) clears all control state, the pattern length, the
//   overflow flag and match_mode; no clearing pass, the block is ready at once.

module edit_distance_engine_top
  import edp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  edp_in_if.sink    in_i,
  edp_out_if.source out_o
);

  // match_mode: 0 whole-string distance, 1 best substring match
  logic  match_mode_q;

  // queued items between front and back
  logic  item_valid;
  logic  item_ready;
  item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      match_mode_q <= cfg_wdata_i;
    end
  end

  // Front: takes each input transfer, decodes the op and buffers it so that the input
  // side can keep flowing, until the queue is full, while the back end walks a row.
  edp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  // Back: holds the pattern, updates the cost row per text char and registers the result
  // so the next items, other than an end-of-text, can be taken while it waits.
  edp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (match_mode_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
